// File: design/gaob_pkg.sv
// ----------------------------------------------------------------------------
// gaob_pkg
// Shared types and constants for the glyph alpha-over blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gaob_pkg;

   localparam int PIX_W    = 8;             // one channel / coverage byte
   localparam int WGT_W    = 16;            // 255*a, (255-a)*da and their sum
   localparam int NUM_W    = 24;            // weighted color numerator
   localparam int CH       = 3;             // color channels
   localparam int DIV_STEPS = 2;            // quotient bits resolved per stage
   localparam int DIV_STAGES = PIX_W / DIV_STEPS;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int FMT_W    = 2;
   localparam int REG_W    = 2;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_GRAY = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RGB  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RGBA = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [REG_W-1:0] REG_FORMAT = 2'd0;
   localparam logic [REG_W-1:0] REG_COLOR0 = 2'd1;
   localparam logic [REG_W-1:0] REG_COLOR1 = 2'd2;
   localparam logic [REG_W-1:0] REG_COLOR2 = 2'd3;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // input beat, coverage in the lowest bits
   typedef struct packed {
      logic [PIX_W-1:0] dst_alpha;
      logic [PIX_W-1:0] dst_c2;
      logic [PIX_W-1:0] dst_c1;
      logic [PIX_W-1:0] dst_c0;
      logic [PIX_W-1:0] coverage;
   } pix_in_type;

   // output beat, out_c0 in the lowest bits
   typedef struct packed {
      logic [PIX_W-1:0] out_alpha;
      logic [PIX_W-1:0] out_c2;
      logic [PIX_W-1:0] out_c1;
      logic [PIX_W-1:0] out_c0;
   } pix_out_type;

   // live configuration
   typedef struct packed {
      logic [FMT_W-1:0]          fmt;
      logic [CH-1:0][PIX_W-1:0]  color;
   } cfg_type;

   // values that ride alongside the divider
   typedef struct packed {
      logic [CH-1:0][PIX_W-1:0] res;        // shift-mode result or passthrough
      logic [PIX_W-1:0]         da;         // destination alpha
      logic                     over;       // four-channel over operator
   } side_type;

endpackage

`default_nettype wire

// File: design/glyph_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// glyph_alpha_over_blend
// Blends a text color over a destination pixel stream, weighted by glyph
// coverage.
//
// Usage:
//   req_* carries one destination pixel and its coverage byte per beat;
//   rsp_* returns one blended pixel per beat, in order. csr_* is an APB-style
//   port for the pixel format and the three text color channels; write it
//   only while no pixel is in flight.
//   The beat is loaded at the accepting edge into the first of seven register
//   stages (two multiply stages, four divider stages of two quotient bits
//   each, and the output register). Throughput is one pixel per cycle while
//   the output is not stalled, set by the fully pipelined divider lanes.
//   Reset clears the registers to grayscale with a black text color and
//   empties the pipeline. With rsp_tvalid high and rsp_tready low the whole
//   pipeline holds; a beat arriving in that cycle lands in a one-entry skid
//   buffer and req_tready drops the cycle after, so nothing is lost or
//   repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_alpha_over_blend (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input pixels
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [7:0] coverage, [15:8] dst_c0, [23:16] dst_c1, [31:24] dst_c2,
   // [39:32] dst_alpha
   input  wire logic [39:0]                  req_tdata,
   // blended pixels
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [7:0] out_c0, [15:8] out_c1, [23:16] out_c2, [31:24] out_alpha
   output logic [31:0]                       rsp_tdata,
   // configuration
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [gaob_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [gaob_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [gaob_pkg::DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int PW = gaob_pkg::PIX_W;
   localparam int WW = gaob_pkg::WGT_W;
   localparam int NW = gaob_pkg::NUM_W;
   localparam int NC = gaob_pkg::CH;

   gaob_pkg::cfg_type            cfg;

   logic                         adv;
   logic                         skid_valid_ff;
   gaob_pkg::pix_in_type         skid_data_ff;
   logic                         src_valid;
   gaob_pkg::pix_in_type         src_pix;

   logic                         fr_valid;
   logic [NC-1:0][NW-1:0]        fr_num;
   logic [WW-1:0]                fr_den;
   gaob_pkg::side_type           fr_side;

   logic                         dv_valid;
   logic [NC-1:0][PW-1:0]        dv_quot;
   logic [WW-1:0]                dv_den;
   gaob_pkg::side_type           dv_side;

   logic                         out_valid_ff;
   gaob_pkg::pix_out_type        out_data_ff, out_data_in;
   logic [WW:0]                  alpha_sum;
   logic                         den_zero;

   gaob_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // whole pipeline moves when the output register can take a beat
   assign adv        = ~out_valid_ff | rsp_tready;
   assign req_tready = ~skid_valid_ff;

   // skid buffer: catches a beat accepted while the pipeline holds
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         skid_valid_ff <= 1'b0;
      end else if (req_tvalid & req_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && !skid_valid_ff) begin
         skid_data_ff <= gaob_pkg::pix_in_type'(req_tdata);
      end
   end

   assign src_valid = skid_valid_ff | req_tvalid;
   assign src_pix   = skid_valid_ff ? skid_data_ff : gaob_pkg::pix_in_type'(req_tdata);

   gaob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (src_valid),
      .in_pix    (src_pix),
      .cfg       (cfg),
      .out_valid (fr_valid),
      .out_num   (fr_num),
      .out_den   (fr_den),
      .out_side  (fr_side)
   );

   gaob_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_den   (dv_den),
      .out_side  (dv_side)
   );

   // final select; alpha = floor(den/255) = (den + (den >> 8) + 1) >> 8
   always_comb begin
      alpha_sum = {1'b0, dv_den} + (WW + 1)'(dv_den[WW-1:PW]) + (WW + 1)'(1);
      den_zero  = (dv_den == '0);
      if (dv_side.over) begin
         out_data_in.out_c0    = den_zero ? dv_side.res[0] : dv_quot[0];
         out_data_in.out_c1    = den_zero ? dv_side.res[1] : dv_quot[1];
         out_data_in.out_c2    = den_zero ? dv_side.res[2] : dv_quot[2];
         out_data_in.out_alpha = alpha_sum[WW-1:PW];
      end else begin
         out_data_in.out_c0    = dv_side.res[0];
         out_data_in.out_c1    = dv_side.res[1];
         out_data_in.out_c2    = dv_side.res[2];
         out_data_in.out_alpha = dv_side.da;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// File: design/gaob_csr.sv
// ----------------------------------------------------------------------------
// gaob_csr
// APB-style register file: pixel format and the three text color channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gaob_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [gaob_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [gaob_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [gaob_pkg::DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output gaob_pkg::cfg_type                 cfg
);

   logic [gaob_pkg::FMT_W-1:0]                         fmt_ff;
   logic [gaob_pkg::CH-1:0][gaob_pkg::PIX_W-1:0]       color_ff;
   logic [gaob_pkg::REG_W-1:0]                         reg_idx;
   logic                                               wr_en;

   assign reg_idx    = csr_paddr[gaob_pkg::ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= '0;
         color_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            gaob_pkg::REG_FORMAT: fmt_ff      <= csr_pwdata[gaob_pkg::FMT_W-1:0];
            gaob_pkg::REG_COLOR0: color_ff[0] <= csr_pwdata[gaob_pkg::PIX_W-1:0];
            gaob_pkg::REG_COLOR1: color_ff[1] <= csr_pwdata[gaob_pkg::PIX_W-1:0];
            gaob_pkg::REG_COLOR2: color_ff[2] <= csr_pwdata[gaob_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         gaob_pkg::REG_FORMAT: csr_prdata = gaob_pkg::DATA_W'(fmt_ff);
         gaob_pkg::REG_COLOR0: csr_prdata = gaob_pkg::DATA_W'(color_ff[0]);
         gaob_pkg::REG_COLOR1: csr_prdata = gaob_pkg::DATA_W'(color_ff[1]);
         gaob_pkg::REG_COLOR2: csr_prdata = gaob_pkg::DATA_W'(color_ff[2]);
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.fmt   = fmt_ff;
   assign cfg.color = color_ff;

endmodule

`default_nettype wire

// File: design/gaob_front.sv
// ----------------------------------------------------------------------------
// gaob_front
// Two multiply stages: weights and shift-mode mixes, then over numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module gaob_front (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          adv,
   input  wire logic                                          in_valid,
   input  wire gaob_pkg::pix_in_type                          in_pix,
   input  wire gaob_pkg::cfg_type                             cfg,
   output logic                                               out_valid,
   output logic [gaob_pkg::CH-1:0][gaob_pkg::NUM_W-1:0]       out_num,
   output logic [gaob_pkg::WGT_W-1:0]                         out_den,
   output gaob_pkg::side_type                                 out_side
);

   localparam int PW = gaob_pkg::PIX_W;
   localparam int WW = gaob_pkg::WGT_W;
   localparam int NW = gaob_pkg::NUM_W;
   localparam int NC = gaob_pkg::CH;

   // stage 1 registers
   logic                        s1_valid_ff;
   logic [WW-1:0]               wa_ff, wa_in;
   logic [WW-1:0]               wb_ff, wb_in;
   logic [NC-1:0][PW-1:0]       dst_ff, dst_in;
   gaob_pkg::side_type          side1_ff, side1_in;

   // stage 2 registers
   logic                        s2_valid_ff;
   logic [NC-1:0][NW-1:0]       num_ff, num_in;
   logic [WW-1:0]               den_ff, den_in;
   gaob_pkg::side_type          side2_ff;

   logic [PW-1:0]               inv_cov;
   logic [NC-1:0][WW-1:0]       mix;
   logic [NC-1:0]               mix_en;
   logic                        is_over;

   // stage 1: weights, shift-mode blend per channel
   always_comb begin
      inv_cov = gaob_pkg::PIX_MAX - in_pix.coverage;
      is_over = (cfg.fmt == gaob_pkg::FMT_RGBA);
      mix_en[0] = (cfg.fmt == gaob_pkg::FMT_GRAY) || (cfg.fmt == gaob_pkg::FMT_RGB);
      mix_en[1] = (cfg.fmt == gaob_pkg::FMT_RGB);
      mix_en[2] = (cfg.fmt == gaob_pkg::FMT_RGB);
      dst_in[0] = in_pix.dst_c0;
      dst_in[1] = in_pix.dst_c1;
      dst_in[2] = in_pix.dst_c2;
      // 255*a = (a << 8) - a
      wa_in = {in_pix.coverage, {PW{1'b0}}} - WW'(in_pix.coverage);
      wb_in = WW'(inv_cov * in_pix.dst_alpha);
      for (int c = 0; c < NC; c++) begin
         mix[c] = WW'(in_pix.coverage * cfg.color[c]) + WW'(inv_cov * dst_in[c]);
         side1_in.res[c] = mix_en[c] ? mix[c][WW-1:PW] : dst_in[c];
      end
      side1_in.da   = in_pix.dst_alpha;
      side1_in.over = is_over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wa_ff    <= wa_in;
         wb_ff    <= wb_in;
         dst_ff   <= dst_in;
         side1_ff <= side1_in;
      end
   end

   // stage 2: over numerators and the shared denominator
   always_comb begin
      den_in = wa_ff + wb_ff;
      for (int c = 0; c < NC; c++) begin
         num_in[c] = NW'(wa_ff * cfg.color[c]) + NW'(wb_ff * dst_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

// File: design/gaob_div.sv
// ----------------------------------------------------------------------------
// gaob_div
// Pipelined restoring divider, three lanes sharing one divisor. Each stage
// resolves DIV_STEPS quotient bits, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module gaob_div (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          adv,
   input  wire logic                                          in_valid,
   input  wire logic [gaob_pkg::CH-1:0][gaob_pkg::NUM_W-1:0]  in_num,
   input  wire logic [gaob_pkg::WGT_W-1:0]                    in_den,
   input  wire gaob_pkg::side_type                            in_side,
   output logic                                               out_valid,
   output logic [gaob_pkg::CH-1:0][gaob_pkg::PIX_W-1:0]       out_quot,
   output logic [gaob_pkg::WGT_W-1:0]                         out_den,
   output gaob_pkg::side_type                                 out_side
);

   localparam int PW = gaob_pkg::PIX_W;
   localparam int WW = gaob_pkg::WGT_W;
   localparam int NW = gaob_pkg::NUM_W;
   localparam int NC = gaob_pkg::CH;
   localparam int NS = gaob_pkg::DIV_STAGES;
   localparam int ST = gaob_pkg::DIV_STEPS;

   logic [NS-1:0]                          vld_ff;
   logic [NS-1:0][NC-1:0][NW-1:0]          rem_ff, rem_in;
   logic [NS-1:0][NC-1:0][PW-1:0]          quot_ff, quot_in;
   logic [NS-1:0][WW-1:0]                  den_ff;
   gaob_pkg::side_type                     side_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                       vld_src;
      logic [NC-1:0][NW-1:0]      rem_src;
      logic [NC-1:0][PW-1:0]      quot_src;
      logic [WW-1:0]              den_src;
      gaob_pkg::side_type         side_src;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = in_num;
         assign quot_src = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign quot_src = quot_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // trial subtract of the shifted divisor, one quotient bit per step
      always_comb begin
         logic [NW:0] trial;
         rem_in[s]  = rem_src;
         quot_in[s] = quot_src;
         for (int c = 0; c < NC; c++) begin
            for (int j = 0; j < ST; j++) begin
               trial = {1'b0, rem_in[s][c]}
                     - {1'b0, NW'(NW'(den_src) << (PW - 1 - s * ST - j))};
               if (!trial[NW]) begin
                  rem_in[s][c] = trial[NW-1:0];
               end
               quot_in[s][c] = {quot_in[s][c][PW-2:0], ~trial[NW]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quot  = quot_ff[NS-1];
   assign out_den   = den_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire
